### rtl/tts_pkg.sv
// Types, constants and clip table function for the tape tone shaper.
package tts_pkg;

  localparam int unsigned ACC_W = 40;

  typedef enum logic [2:0] {
    REG_INPUT_GAIN   = 3'd0,
    REG_SOFTEN       = 3'd1,
    REG_STAGE_COEFF  = 3'd2,
    REG_ROLL_COEFF   = 3'd3,
    REG_OUTPUT_GAIN  = 3'd4,
    REG_WET_MIX      = 3'd5,
    REG_NOISE_SEED   = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_RD,
    ST_STAGE,
    ST_SUM,
    ST_ROLL_A,
    ST_ROLL_B,
    ST_ROLL_C,
    ST_CLIP_A,
    ST_CLIP_B,
    ST_OGAIN,
    ST_MIX,
    ST_OUT
  } state_e;

  // Saturate a wide signed value to 40 bits.
  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = (64'sd1 <<< (ACC_W-1)) - 64'sd1;
      lo = -(64'sd1 <<< (ACC_W-1));
      if (v > hi) sat40 = hi[ACC_W-1:0];
      else if (v < lo) sat40 = lo[ACC_W-1:0];
      else sat40 = v[ACC_W-1:0];
    end
  endfunction

  // Clip table entry: 1-cos(y) in Q0.30 by an integer Horner chain.
  // Divisions here are by literal constants or the table depth; evaluated for constant indices.
  function automatic logic [31:0] clip_entry(input logic [12:0] i,
                                             input int unsigned depth);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] g;
    logic [63:0] one;
    begin
      one = 64'd1 << 30;
      y = (64'(i) * 64'd1686629713) / 64'(depth);
      y2 = (y * y) >> 30;
      g = one - y2 / 132;
      g = one - ((y2 * g) >> 30) / 90;
      g = one - ((y2 * g) >> 30) / 56;
      g = one - ((y2 * g) >> 30) / 30;
      g = one - ((y2 * g) >> 30) / 12;
      clip_entry = 32'(((y2 * g) >> 30) / 2);
    end
  endfunction

endpackage

### rtl/tape_tone_shaper_core.sv
// Tape tone shaper core: one item in, one item out. An item occupies the core from the
// edge that accepts it to the first edge that can accept the next; its result becomes
// valid when its rounding step finishes. At the heart of this is the stage loop: it reads,
// updates and writes back one stage entry of the stage memory per cycle. Fixed steps
// surround it: gain, read set-up, stage sum, three roller steps, two clip steps, output
// gain, mix and rounding. After reset a clearing pass zeroes the stage memory, during
// which no item is taken; configuration writes are taken at any time. The finished item
// sits in an output register until taken. The next item may be accepted meanwhile, and
// its rounding step holds until that register is free.
module tape_tone_shaper_core #(
  parameter int unsigned STAGE_COUNT      = 26,
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned CLIP_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);
  localparam int unsigned AW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int unsigned CW = $clog2(CLIP_TABLE_DEPTH);
  localparam int unsigned IN_SHIFT = 38 - SAMPLE_BITS;
  localparam int unsigned W = tts_pkg::ACC_W;

  // Clip table, built at elaboration.
  logic [31:0] clip_rom [CLIP_TABLE_DEPTH+1];
  for (genvar g = 0; g <= CLIP_TABLE_DEPTH; g++) begin : g_rom
    assign clip_rom[g] = tts_pkg::clip_entry(13'(g), CLIP_TABLE_DEPTH);
  end

  // Configuration registers.
  logic [17:0] in_gain_q, out_gain_q;
  logic [16:0] soften_q, roll_q, wet_q;
  logic [24:0] stage_c_q;
  logic [31:0] noise_q;

  tts_pkg::state_e state_q, state_d;
  logic [AW-1:0] k_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic [1:0]    rsel_q;
  logic signed [W-1:0] roll_q0, roll_q1, roll_q2;

  logic signed [W-1:0] dry_q, x_q, t_q, q_q, h_q, acc_q;
  logic signed [63:0]  sum_q;
  logic [16:0] rnd_q;
  logic [CW:0] idx_q;
  logic [15:0] frac_q;
  logic signed [SAMPLE_BITS-1:0] res_q;
  logic out_v_q;

  // Saturated register values.
  logic [17:0] ig, og;
  logic [16:0] sa, rc, wm;
  logic [24:0] sc;
  assign ig = (in_gain_q  > 18'd131072) ? 18'd131072 : in_gain_q;
  assign og = (out_gain_q > 18'd131072) ? 18'd131072 : out_gain_q;
  assign sa = (soften_q > 17'd65536) ? 17'd65536 : soften_q;
  assign rc = (roll_q   > 17'd65536) ? 17'd65536 : roll_q;
  assign wm = (wet_q    > 17'd65536) ? 17'd65536 : wet_q;
  assign sc = (stage_c_q > 25'd16777216) ? 25'd16777216 : stage_c_q;

  // Stage memory.
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic signed [W-1:0] mem_wd, mem_rd;

  tts_stage_mem #(.DEPTH(STAGE_COUNT), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // Stage update: m' = sat(m + floor((t-m)*a / 2^24)).
  logic signed [W:0]    diff;
  logic signed [66:0]   sprod;
  logic signed [W-1:0]  m_new;
  assign diff  = W'(0) + ({t_q[W-1], t_q} - {mem_rd[W-1], mem_rd});
  assign sprod = diff * $signed({1'b0, sc});
  assign m_new = tts_pkg::sat40(64'(mem_rd) + 64'(sprod >>> 24));

  assign mem_we = clr_q || (state_q == tts_pkg::ST_STAGE);
  assign mem_wa = clr_q ? clr_cnt_q : k_q;
  assign mem_wd = clr_q ? '0 : m_new;
  assign mem_ra = (state_q == tts_pkg::ST_STAGE && k_q != AW'(STAGE_COUNT-1))
                  ? k_q + AW'(1) : AW'(0);

  // Current roller and its neighbours.
  logic [1:0] n;
  logic signed [W-1:0] rn, o1, o2;
  assign n = (rsel_q == 2'd0) ? 2'd0 : rsel_q - 2'd1;
  always_comb begin
    case (n)
      2'd1:    begin rn = roll_q1; o1 = roll_q2; o2 = roll_q0; end
      2'd2:    begin rn = roll_q2; o1 = roll_q0; o2 = roll_q1; end
      default: begin rn = roll_q0; o1 = roll_q1; o2 = roll_q2; end
    endcase
  end

  logic [15:0] half;
  logic [16:0] inv;
  assign half = rnd_q[16:1];
  assign inv  = 17'd65536 - rnd_q;

  // Products, each used in one state (results registered between states).
  logic signed [W:0]  rdiff;
  logic signed [63:0] p_roll, p_q, p_o1, p_o2, p_og, p_wet, p_dry, p_in;
  assign rdiff  = {x_q[W-1], x_q} - {rn[W-1], rn};
  assign p_roll = 64'(rdiff) * 64'($signed({1'b0, rc}));
  assign p_q    = 64'(q_q) * 64'($signed({1'b0, inv}));
  assign p_o1   = 64'(o1) * 64'($signed({1'b0, half}));
  assign p_o2   = 64'(o2) * 64'($signed({1'b0, half}));
  assign p_og   = 64'(x_q) * 64'($signed({1'b0, og}));
  assign p_wet  = 64'(x_q) * 64'($signed({1'b0, wm}));
  assign p_dry  = 64'(dry_q) * 64'($signed({1'b0, 17'd65536 - wm}));
  assign p_in   = 64'(dry_q) * 64'($signed({1'b0, ig}));

  // Clip index and interpolation.
  logic [W-1:0] habs;
  logic [37:0]  u;
  logic [37+CW:0] pidx;
  assign habs = h_q[W-1] ? W'(-h_q) : W'(h_q);
  assign u    = (habs > W'(64'd1 << 37)) ? 38'(64'd1 << 37) : habs[37:0];
  assign pidx = (37+CW+1)'(u) << CW;

  logic [31:0] t0, t1;
  logic [48:0] interp;
  logic signed [W-1:0] vclip;
  assign t0 = clip_rom[idx_q[CW-1:0]];
  assign t1 = clip_rom[idx_q[CW-1:0] + (CW+1)'(1)];
  assign interp = 49'(t1 - t0) * 49'(frac_q);
  always_comb begin
    if (idx_q[CW]) vclip = W'(clip_rom[CLIP_TABLE_DEPTH]) <<< 7;
    else vclip = W'(t0 + 32'(interp >> 16)) <<< 7;
  end

  // Output rounding.
  logic signed [W:0]  rnd_x;
  logic signed [W:0]  shx;
  assign rnd_x = {x_q[W-1], x_q} + (W+1)'(64'd1 << (IN_SHIFT-1));
  assign shx   = rnd_x >>> IN_SHIFT;

  // Finish the rounding step only once the output register is free or being taken.
  logic accept_in, accept_out, out_go;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign accept_out = out_v_q && !out_stall_i;
  assign out_go     = (state_q == tts_pkg::ST_OUT) && (!out_v_q || accept_out);
  assign in_stall_o = clr_q || (state_q != tts_pkg::ST_IDLE);
  assign out_valid_o = out_v_q;
  assign sample_out_o = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tts_pkg::ST_IDLE:   if (accept_in) state_d = tts_pkg::ST_GAIN;
      tts_pkg::ST_GAIN:   state_d = tts_pkg::ST_RD;
      tts_pkg::ST_RD:     state_d = tts_pkg::ST_STAGE;
      tts_pkg::ST_STAGE:  if (k_q == AW'(STAGE_COUNT-1)) state_d = tts_pkg::ST_SUM;
      tts_pkg::ST_SUM:    state_d = tts_pkg::ST_ROLL_A;
      tts_pkg::ST_ROLL_A: state_d = tts_pkg::ST_ROLL_B;
      tts_pkg::ST_ROLL_B: state_d = tts_pkg::ST_ROLL_C;
      tts_pkg::ST_ROLL_C: state_d = tts_pkg::ST_CLIP_A;
      tts_pkg::ST_CLIP_A: state_d = tts_pkg::ST_CLIP_B;
      tts_pkg::ST_CLIP_B: state_d = tts_pkg::ST_OGAIN;
      tts_pkg::ST_OGAIN:  state_d = tts_pkg::ST_MIX;
      tts_pkg::ST_MIX:    state_d = tts_pkg::ST_OUT;
      tts_pkg::ST_OUT:    if (out_go) state_d = tts_pkg::ST_IDLE;
      default:            state_d = tts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tts_pkg::ST_IDLE;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      k_q       <= '0;
      rsel_q    <= 2'd1;
      roll_q0   <= '0;
      roll_q1   <= '0;
      roll_q2   <= '0;
      out_v_q   <= 1'b0;
      in_gain_q <= 18'd65536;
      soften_q  <= 17'd32768;
      stage_c_q <= 25'd67109;
      roll_q    <= 17'd32768;
      out_gain_q <= 18'd65536;
      wet_q     <= 17'd65536;
      noise_q   <= 32'd16386;
    end else begin
      state_q <= state_d;
      // Clear stage memory once after reset.
      if (clr_q) begin
        if (clr_cnt_q == AW'(STAGE_COUNT-1)) clr_q <= 1'b0;
        else clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (out_go) out_v_q <= 1'b1;
      else if (accept_out) out_v_q <= 1'b0;
      if (state_q == tts_pkg::ST_RD) k_q <= '0;
      if (state_q == tts_pkg::ST_STAGE) k_q <= k_q + AW'(1);
      if (state_q == tts_pkg::ST_ROLL_B) begin
        case (n)
          2'd1:    roll_q1 <= tts_pkg::sat40(64'(acc_q) + (p_q >>> 16));
          2'd2:    roll_q2 <= tts_pkg::sat40(64'(acc_q) + (p_q >>> 16));
          default: roll_q0 <= tts_pkg::sat40(64'(acc_q) + (p_q >>> 16));
        endcase
      end
      // Advance the roller choice once the high band has used the updated roller.
      if (state_q == tts_pkg::ST_ROLL_C) rsel_q <= (n == 2'd2) ? 2'd0 : n + 2'd2;
      if (out_go && !(cfg_we_i && cfg_index_i == tts_pkg::REG_NOISE_SEED)) begin
        noise_q <= noise_q ^ (noise_q << 13) ^ ((noise_q ^ (noise_q << 13)) >> 17)
                   ^ ((noise_q ^ (noise_q << 13) ^ ((noise_q ^ (noise_q << 13)) >> 17))
                      << 5);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          tts_pkg::REG_INPUT_GAIN:  in_gain_q  <= cfg_data_i[17:0];
          tts_pkg::REG_SOFTEN:      soften_q   <= cfg_data_i[16:0];
          tts_pkg::REG_STAGE_COEFF: stage_c_q  <= cfg_data_i[24:0];
          tts_pkg::REG_ROLL_COEFF:  roll_q     <= cfg_data_i[16:0];
          tts_pkg::REG_OUTPUT_GAIN: out_gain_q <= cfg_data_i[17:0];
          tts_pkg::REG_WET_MIX:     wet_q      <= cfg_data_i[16:0];
          tts_pkg::REG_NOISE_SEED:  noise_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  logic [48:0] noise_prod;
  assign noise_prod = 49'(noise_q) * 49'(sa);

  always_ff @(posedge clk_i) begin
    case (state_q)
      tts_pkg::ST_IDLE: begin
        if (accept_in) dry_q <= W'(sample_in_i) <<< IN_SHIFT;
      end
      tts_pkg::ST_GAIN: begin
        x_q   <= W'(p_in >>> 16);
        t_q   <= W'(p_in >>> 16);
        sum_q <= '0;
        rnd_q <= noise_prod[48:32];
      end
      tts_pkg::ST_STAGE: begin
        t_q   <= tts_pkg::sat40(64'(t_q) - 64'(m_new));
        sum_q <= sum_q + 64'(m_new);
      end
      tts_pkg::ST_SUM:    x_q <= tts_pkg::sat40(64'(x_q) - sum_q);
      tts_pkg::ST_ROLL_A: begin
        q_q   <= W'(64'(rn) + (p_roll >>> 16));
        acc_q <= W'((p_o1 >>> 16) + (p_o2 >>> 16));
      end
      tts_pkg::ST_ROLL_C: h_q <= tts_pkg::sat40(64'(x_q) - 64'(rn));
      tts_pkg::ST_CLIP_A: begin
        idx_q  <= pidx[37+CW:37];
        frac_q <= pidx[36:21];
      end
      tts_pkg::ST_CLIP_B: begin
        if (!h_q[W-1] && h_q != '0) x_q <= tts_pkg::sat40(64'(x_q) - 64'(vclip));
        else if (h_q[W-1]) x_q <= tts_pkg::sat40(64'(x_q) + 64'(vclip));
      end
      tts_pkg::ST_OGAIN:  x_q <= tts_pkg::sat40(p_og >>> 16);
      tts_pkg::ST_MIX:    x_q <= tts_pkg::sat40((p_wet >>> 16) + (p_dry >>> 16));
      tts_pkg::ST_OUT: begin
        if (out_go) begin
          if (shx > (W+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1))
            res_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          else if (shx < -((W+1)'(64'sd1 <<< (SAMPLE_BITS-1))))
            res_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          else
            res_q <= shx[SAMPLE_BITS-1:0];
        end
      end
      default: ;
    endcase
  end
endmodule

### rtl/tts_stage_mem.sv
// Stage state memory: synchronous RAM with registered read.
module tts_stage_mem #(
  parameter int unsigned DEPTH = 26,
  parameter int unsigned AW    = 5
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [AW-1:0]                        waddr_i,
  input  logic signed [tts_pkg::ACC_W-1:0]     wdata_i,
  input  logic [AW-1:0]                        raddr_i,
  output logic signed [tts_pkg::ACC_W-1:0]     rdata_o
);
  logic signed [tts_pkg::ACC_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### tb/tape_tone_shaper_core_tb.sv
// Self-checking testbench for the tape tone shaper core.
`timescale 1ns / 100ps

module tape_tone_shaper_core_tb;

  localparam int unsigned STAGES = 26;
  localparam int unsigned SBITS = 24;
  localparam int unsigned DEPTH = 256;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam longint OUT_HI = 64'sd8388607;
  localparam longint OUT_LO = -64'sd8388608;
  localparam longint UNIT37 = 64'sd137438953472;

  // Bit-exact model of the shaper plus the queue of samples it still owes.
  class tone_scoreboard;
    longint unsigned in_gain, soften, stage_a, roll_r, out_gain, wet;
    longint stage_mem[STAGES];
    longint roll_mem[3];
    int unsigned roll_sel;
    logic [31:0] noise;
    longint unsigned clip_tbl[DEPTH+1];
    logic [SBITS-1:0] owed[$];

    function new();
      longint unsigned y, y2, g, one;
      one = 64'd1 << 30;
      in_gain = 65536; soften = 32768; stage_a = 67109;
      roll_r = 32768; out_gain = 65536; wet = 65536;
      noise = 32'd16386;
      roll_sel = 1;
      foreach (stage_mem[k]) stage_mem[k] = 0;
      foreach (roll_mem[k]) roll_mem[k] = 0;
      for (int i = 0; i <= DEPTH; i++) begin
        y = (longint'(i) * 64'd1686629713) / DEPTH;
        y2 = (y * y) >> 30;
        g = one - y2 / 132;
        g = one - ((y2 * g) >> 30) / 90;
        g = one - ((y2 * g) >> 30) / 56;
        g = one - ((y2 * g) >> 30) / 30;
        g = one - ((y2 * g) >> 30) / 12;
        clip_tbl[i] = ((y2 * g) >> 30) / 2;
      end
    endfunction

    function longint clamp40(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    function longint unsigned limit(longint unsigned v, longint unsigned m);
      return (v > m) ? m : v;
    endfunction

    // floor(d*c / 2^fb) without overflowing 64 bits
    function longint scale(longint d, longint unsigned c, int fb);
      longint hi, lo;
      hi = d * longint'(c >> 12);
      lo = (d * longint'(c & 64'hFFF)) >>> 12;
      return (hi + lo) >>> (fb - 12);
    endfunction

    function void set_reg(tts_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        tts_pkg::REG_INPUT_GAIN:  in_gain = val[17:0];
        tts_pkg::REG_SOFTEN:      soften = val[16:0];
        tts_pkg::REG_STAGE_COEFF: stage_a = val[24:0];
        tts_pkg::REG_ROLL_COEFF:  roll_r = val[16:0];
        tts_pkg::REG_OUTPUT_GAIN: out_gain = val[17:0];
        tts_pkg::REG_WET_MIX:     wet = val[16:0];
        tts_pkg::REG_NOISE_SEED:  noise = val;
        default: ;
      endcase
    endfunction

    // Run one sample through the model and queue what the block must return.
    function void note_sample(logic signed [SBITS-1:0] smp);
      longint dry, x, t, sum, m, q, h, u, v, o1, o2, res;
      longint unsigned a, w, rnd, half, inv, p, idx, frac, t0, t1;
      int n;
      a = limit(stage_a, 16777216);
      w = limit(wet, 65536);
      dry = longint'(smp) <<< 14;
      x = scale(dry, limit(in_gain, 131072), 16);
      rnd = (longint'(noise) * limit(soften, 65536)) >> 32;
      half = rnd >> 1;
      inv = 65536 - rnd;
      t = x; sum = 0;
      for (int k = 0; k < STAGES; k++) begin
        m = clamp40(stage_mem[k] + scale(t - stage_mem[k], a, 24));
        stage_mem[k] = m;
        t = clamp40(t - m);
        sum += m;
      end
      x = clamp40(x - sum);
      if (roll_sel < 1 || roll_sel > 3) roll_sel = 1;
      n = roll_sel - 1;
      o1 = roll_mem[(n + 1) % 3];
      o2 = roll_mem[(n + 2) % 3];
      q = roll_mem[n] + scale(x - roll_mem[n], limit(roll_r, 65536), 16);
      roll_mem[n] = clamp40(scale(q, inv, 16) + scale(o1, half, 16) + scale(o2, half, 16));
      h = clamp40(x - roll_mem[n]);
      roll_sel = (roll_sel + 1) & 3;
      u = (h < 0) ? -h : h;
      if (u > UNIT37) u = UNIT37;
      p = longint'(u) * DEPTH;
      idx = p >> 37;
      if (idx >= DEPTH) begin
        v = clip_tbl[DEPTH];
      end else begin
        frac = (p & ((64'd1 << 37) - 1)) >> 21;
        t0 = clip_tbl[idx];
        t1 = clip_tbl[idx + 1];
        v = t0 + (((t1 - t0) * frac) >> 16);
      end
      v = v * 128;
      if (h > 0) x = clamp40(x - v);
      else if (h < 0) x = clamp40(x + v);
      x = clamp40(scale(x, limit(out_gain, 131072), 16));
      x = clamp40(scale(x, w, 16) + scale(dry, 65536 - w, 16));
      res = (x + 8192) >>> 14;
      if (res > OUT_HI) res = OUT_HI;
      if (res < OUT_LO) res = OUT_LO;
      owed.push_back(res[SBITS-1:0]);
      noise = noise ^ (noise << 13);
      noise = noise ^ (noise >> 17);
      noise = noise ^ (noise << 5);
    endfunction

    // Pop the oldest owed sample; 0 if none was owed or it differs.
    function bit check_result(logic [SBITS-1:0] got, output logic [SBITS-1:0] want,
                              output bit was_owed);
      was_owed = (owed.size() != 0);
      want = '0;
      if (!was_owed) return 0;
      want = owed.pop_front();
      return want == got;
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SBITS-1:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SBITS-1:0] sample_out_o;

  tone_scoreboard shaper_sb;
  int errors = 0;
  bit stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  tape_tone_shaper_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sample_in_i(sample_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_out_o(sample_out_o)
  );

  task automatic report_mismatch(string what, logic [SBITS-1:0] want, logic [SBITS-1:0] got);
    errors++;
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, $signed(want), $signed(got),
             $realtime);
  endtask

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Note every item taken at the input.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) shaper_sb.note_sample(sample_in_i);
  end

  // Check every item taken at the output against the oldest owed one.
  always @(posedge clk_i) begin
    logic [SBITS-1:0] want;
    bit owed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (!shaper_sb.check_result(sample_out_o, want, owed))
        report_mismatch(owed ? "sample_out" : "unexpected item", want, sample_out_o);
    end
  end

  // Receiver back-pressure: bursts of stall with calm stretches between.
  initial begin
    int calm;
    forever begin
      calm = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 8);
      out_stall_i <= 1'b0;
      repeat (calm + 1) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk_i);
    end
  end

  // Offer one item and hold it until taken.
  task automatic send_sample(logic signed [SBITS-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, drain every owed item, let the core settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shaper_sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(tts_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    shaper_sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] ig, logic [31:0] sa, logic [31:0] sc,
                           logic [31:0] rc, logic [31:0] og, logic [31:0] wm,
                           logic [31:0] seed);
    write_reg(tts_pkg::REG_INPUT_GAIN, ig);
    write_reg(tts_pkg::REG_SOFTEN, sa);
    write_reg(tts_pkg::REG_STAGE_COEFF, sc);
    write_reg(tts_pkg::REG_ROLL_COEFF, rc);
    write_reg(tts_pkg::REG_OUTPUT_GAIN, og);
    write_reg(tts_pkg::REG_WET_MIX, wm);
    write_reg(tts_pkg::REG_NOISE_SEED, seed);
  endtask

  // Random sample: full range, near silence, or a rail.
  function automatic logic signed [SBITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 24'($urandom());
    if (r < 8) return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
    return r[0] ? 24'sh7FFFFF : 24'sh800000;
  endfunction

  task automatic random_burst(int count);
    repeat (count) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    shaper_sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: rails, zero, tiny values, a square wave to excite the clip.
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample('0);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'sh7FFFFF : 24'sh800000);
    for (int i = 0; i < 4; i++) send_sample('0);
    random_burst(150);

    // Every register at its top value.
    write_all(131072, 65536, 16777216, 65536, 131072, 65536, 32'hFFFF_FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample('0);
    random_burst(130);

    // Every register at zero: silent wet path, zero seed freezes the noise.
    write_all(0, 0, 0, 0, 0, 0, 0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    random_burst(60);

    // Zero seed with full soften, all dry mix off.
    write_all(65536, 65536, 67109, 32768, 65536, 65536, 0);
    random_burst(60);

    // Over-range values: all bits set in every limited register, must act as the maxima.
    write_all(32'h3FFFF, 32'h1FFFF, 32'h1FFFFFF, 32'h1FFFF, 32'h3FFFF, 32'h1FFFF, 16386);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    random_burst(120);

    // Random settings for the rest.
    for (int ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(0, 131072), $urandom_range(0, 65536),
                $urandom_range(0, 16777216), $urandom_range(0, 65536),
                $urandom_range(0, 131072), $urandom_range(0, 65536), $urandom());
      random_burst(75);
    end

    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (60) @(posedge clk_i);
    if (shaper_sb.pending() != 0) begin
      report_mismatch("items never returned", SBITS'(shaper_sb.pending()), '0);
    end
    if (errors == 0) begin
      $display("tape_tone_shaper_core_tb: done, clean");
    end else begin
      $display("tape_tone_shaper_core_tb: done, errors");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("TIMEOUT");
    $display("tape_tone_shaper_core_tb: done, errors");
    $finish;
  end

endmodule

### tape_tone_shaper_core.f
rtl/tts_pkg.sv
rtl/tts_stage_mem.sv
rtl/tape_tone_shaper_core.sv
tb/tape_tone_shaper_core_tb.sv
